[hdl/blm_pkg.sv]
// shared types and constants for the battery level monitor
package blm_pkg;

    typedef logic [2:0] level_t;
    typedef logic [1:0] task_t;
    typedef logic [7:0] count_t;
    typedef logic [1:0] cfg_index_t;
    typedef logic [9:0] cfg_data_t;

    // configuration register indexes
    localparam cfg_index_t CFG_DEBOUNCE_LIMIT = 2'd0;
    localparam cfg_index_t CFG_VALID_FLOOR    = 2'd1;
    localparam cfg_index_t CFG_CUTOFF_LEVEL   = 2'd2;
    localparam cfg_index_t CFG_WARNING_LEVEL  = 2'd3;

    // register reset values
    localparam count_t    DEBOUNCE_RESET = 8'd100;
    localparam cfg_data_t FLOOR_RESET    = 10'd200;
    localparam cfg_data_t CUTOFF_RESET   = 10'd345;
    localparam cfg_data_t WARNING_RESET  = 10'd355;

    // task request codes
    localparam task_t TASK_NONE   = 2'd0;
    localparam task_t TASK_LOW    = 2'd1;
    localparam task_t TASK_NORMAL = 2'd2;

    // level band edges: band 0 runs from the valid floor up to LVL0_HI, each other band is (lo, hi]
    localparam int LVL0_HI = 350;
    localparam int LVL1_HI = 360;
    localparam int LVL2_LO = 365;
    localparam int LVL2_HI = 375;
    localparam int LVL3_LO = 380;
    localparam int LVL3_HI = 390;
    localparam int LVL4_LO = 395;
    localparam int LVL4_HI = 405;
    localparam int LVL5_LO = 410;
    localparam int LVL5_HI = 500;

    localparam count_t COUNT_MAX = 8'd255;
    localparam int     REG_BITS  = 10;

endpackage

[hdl/blm_in_if.sv]
// sample channel: valid/ready with one ADC sample and the start-up flag
interface blm_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   in_start_task;

    modport source (output valid, output sample, output in_start_task, input ready);
    modport sink   (input valid, input sample, input in_start_task, output ready);
endinterface

[hdl/blm_out_if.sv]
// result channel: valid/ready with the monitor status of one sample
interface blm_out_if;
    logic                valid;
    logic                ready;
    blm_pkg::level_t     battery_level;
    logic                icon_valid;
    blm_pkg::level_t     icon_index;
    blm_pkg::task_t      task_request;
    logic                start_low_flag;
    logic                primary_low_flag;
    logic                low_voltage_flag;
    logic                cancel_call;

    modport source (
        output valid, output battery_level, output icon_valid, output icon_index,
        output task_request, output start_low_flag, output primary_low_flag,
        output low_voltage_flag, output cancel_call, input ready
    );
    modport sink (
        input valid, input battery_level, input icon_valid, input icon_index,
        input task_request, input start_low_flag, input primary_low_flag,
        input low_voltage_flag, input cancel_call, output ready
    );
endinterface

[hdl/blm_cfg_if.sv]
// configuration write channel: register index and write data
interface blm_cfg_if;
    logic                  valid;
    logic                  ready;
    blm_pkg::cfg_index_t   index;
    blm_pkg::cfg_data_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/battery_level_monitor.sv]
// battery level monitor: debounced low/warning detection and level mapping
// path: a sample passes the input register and then the result register to reach its result beat
// throughput: one sample per cycle; the result register holds while the sink stalls
// and the input register keeps taking a sample whenever the result register can advance
// reset: counters, flags and level clear to zero, configuration registers load their defaults
// configuration port is always ready; writes take effect on the next cycle
module battery_level_monitor #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    blm_in_if.sink     samples,
    blm_out_if.source  results,
    blm_cfg_if.sink    cfg
);

    localparam int CMP_W = (SAMPLE_BITS > blm_pkg::REG_BITS) ? SAMPLE_BITS
                                                             : blm_pkg::REG_BITS;

    // configuration registers
    blm_pkg::count_t    debounce_limit_reg;
    blm_pkg::cfg_data_t valid_floor_reg;
    blm_pkg::cfg_data_t cutoff_level_reg;
    blm_pkg::cfg_data_t warning_level_reg;

    // input stage
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_start_reg;

    // monitor state
    blm_pkg::level_t level_reg,         level_next;
    blm_pkg::count_t cutoff_count_reg,  cutoff_count_next;
    blm_pkg::count_t warning_count_reg, warning_count_next;
    blm_pkg::count_t startup_count_reg, startup_count_next;
    logic            low_voltage_reg,   low_voltage_next;
    logic            start_low_reg,     start_low_next;
    logic            primary_low_reg,   primary_low_next;

    // result register
    logic            out_valid_reg;
    logic            icon_valid_reg,    icon_valid_next;
    blm_pkg::level_t icon_index_reg,    icon_index_next;
    blm_pkg::task_t  task_reg,          task_next;
    logic            cancel_reg,        cancel_next;

    logic out_advance;
    logic s1_ready;
    logic s1_fire;

    logic [CMP_W-1:0] s_ext;
    logic [CMP_W-1:0] floor_ext;
    logic [CMP_W-1:0] cutoff_ext;
    logic [CMP_W-1:0] warning_ext;
    logic             in_floor;
    logic             band_hit;
    blm_pkg::level_t  band_level;
    blm_pkg::count_t  startup_inc;
    blm_pkg::count_t  cutoff_inc;
    blm_pkg::count_t  warning_inc;

    // handshake: result register advances when empty or taken
    assign out_advance   = !out_valid_reg || results.ready;
    assign s1_ready      = !s1_valid_reg || out_advance;
    assign s1_fire       = s1_valid_reg && out_advance;
    assign samples.ready = s1_ready;
    assign cfg.ready     = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_limit_reg <= blm_pkg::DEBOUNCE_RESET;
            valid_floor_reg    <= blm_pkg::FLOOR_RESET;
            cutoff_level_reg   <= blm_pkg::CUTOFF_RESET;
            warning_level_reg  <= blm_pkg::WARNING_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                blm_pkg::CFG_DEBOUNCE_LIMIT: debounce_limit_reg <= cfg.data[7:0];
                blm_pkg::CFG_VALID_FLOOR:    valid_floor_reg    <= cfg.data;
                blm_pkg::CFG_CUTOFF_LEVEL:   cutoff_level_reg   <= cfg.data;
                blm_pkg::CFG_WARNING_LEVEL:  warning_level_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && samples.valid)
        begin
            s1_sample_reg <= samples.sample;
            s1_start_reg  <= samples.in_start_task;
        end
    end

    // comparisons at a common width
    assign s_ext       = CMP_W'(s1_sample_reg);
    assign floor_ext   = CMP_W'(valid_floor_reg);
    assign cutoff_ext  = CMP_W'(cutoff_level_reg);
    assign warning_ext = CMP_W'(warning_level_reg);
    assign in_floor    = (s_ext >= floor_ext);

    // level band lookup
    always_comb
    begin
        band_hit   = 1'b1;
        band_level = 3'd0;
        if (in_floor && s_ext <= CMP_W'(blm_pkg::LVL0_HI))
            band_level = 3'd0;
        else if (s_ext > CMP_W'(blm_pkg::LVL0_HI) && s_ext <= CMP_W'(blm_pkg::LVL1_HI))
            band_level = 3'd1;
        else if (s_ext > CMP_W'(blm_pkg::LVL2_LO) && s_ext <= CMP_W'(blm_pkg::LVL2_HI))
            band_level = 3'd2;
        else if (s_ext > CMP_W'(blm_pkg::LVL3_LO) && s_ext <= CMP_W'(blm_pkg::LVL3_HI))
            band_level = 3'd3;
        else if (s_ext > CMP_W'(blm_pkg::LVL4_LO) && s_ext <= CMP_W'(blm_pkg::LVL4_HI))
            band_level = 3'd4;
        else if (s_ext > CMP_W'(blm_pkg::LVL5_LO) && s_ext <= CMP_W'(blm_pkg::LVL5_HI))
            band_level = 3'd5;
        else
            band_hit = 1'b0;
    end

    // saturating increments
    assign startup_inc = (startup_count_reg == blm_pkg::COUNT_MAX) ? blm_pkg::COUNT_MAX
                                                                   : startup_count_reg + 8'd1;
    assign cutoff_inc  = (cutoff_count_reg == blm_pkg::COUNT_MAX) ? blm_pkg::COUNT_MAX
                                                                  : cutoff_count_reg + 8'd1;
    assign warning_inc = (warning_count_reg == blm_pkg::COUNT_MAX) ? blm_pkg::COUNT_MAX
                                                                   : warning_count_reg + 8'd1;

    // per-sample decision
    always_comb
    begin
        level_next         = level_reg;
        cutoff_count_next  = cutoff_count_reg;
        warning_count_next = warning_count_reg;
        startup_count_next = startup_count_reg;
        low_voltage_next   = low_voltage_reg;
        start_low_next     = start_low_reg;
        primary_low_next   = primary_low_reg;
        icon_valid_next    = 1'b0;
        icon_index_next    = 3'd0;
        task_next          = blm_pkg::TASK_NONE;
        cancel_next        = 1'b0;

        if (s1_start_reg)
        begin
            // start-up: debounce the low band, map the level
            if (in_floor && s_ext <= warning_ext)
            begin
                startup_count_next = startup_inc;
                if (startup_inc > debounce_limit_reg)
                    start_low_next = 1'b1;
            end
            else
            begin
                startup_count_next = 8'd0;
            end
            if (band_hit)
            begin
                level_next      = band_level;
                icon_valid_next = 1'b1;
                icon_index_next = band_level;
            end
        end
        else if (in_floor && s_ext <= cutoff_ext)
        begin
            // cutoff band
            cutoff_count_next = cutoff_inc;
            if (cutoff_inc >= debounce_limit_reg)
            begin
                icon_valid_next   = 1'b1;
                task_next         = blm_pkg::TASK_LOW;
                low_voltage_next  = 1'b1;
                cutoff_count_next = 8'd0;
            end
        end
        else if (s_ext > cutoff_ext && s_ext < warning_ext)
        begin
            // warning band
            warning_count_next = warning_inc;
            if (warning_inc >= debounce_limit_reg)
            begin
                icon_valid_next    = 1'b1;
                task_next          = blm_pkg::TASK_NORMAL;
                primary_low_next   = 1'b1;
                warning_count_next = 8'd0;
            end
        end
        else
        begin
            // normal operation, cancel pulse after recovery
            task_next = blm_pkg::TASK_NORMAL;
            if (band_hit)
            begin
                level_next      = band_level;
                icon_valid_next = 1'b1;
                icon_index_next = band_level;
            end
            if (low_voltage_reg)
            begin
                cancel_next      = 1'b1;
                low_voltage_next = 1'b0;
            end
        end
    end

    // state update per processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg         <= 3'd0;
            cutoff_count_reg  <= 8'd0;
            warning_count_reg <= 8'd0;
            startup_count_reg <= 8'd0;
            low_voltage_reg   <= 1'b0;
            start_low_reg     <= 1'b0;
            primary_low_reg   <= 1'b0;
        end
        else if (s1_fire)
        begin
            level_reg         <= level_next;
            cutoff_count_reg  <= cutoff_count_next;
            warning_count_reg <= warning_count_next;
            startup_count_reg <= startup_count_next;
            low_voltage_reg   <= low_voltage_next;
            start_low_reg     <= start_low_next;
            primary_low_reg   <= primary_low_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            icon_valid_reg <= icon_valid_next;
            icon_index_reg <= icon_index_next;
            task_reg       <= task_next;
            cancel_reg     <= cancel_next;
        end
    end

    // flags and level follow the state registers, which only move with the result beat
    assign results.valid            = out_valid_reg;
    assign results.battery_level    = level_reg;
    assign results.icon_valid       = icon_valid_reg;
    assign results.icon_index       = icon_index_reg;
    assign results.task_request     = task_reg;
    assign results.start_low_flag   = start_low_reg;
    assign results.primary_low_flag = primary_low_reg;
    assign results.low_voltage_flag = low_voltage_reg;
    assign results.cancel_call      = cancel_reg;

endmodule
